[src/assert_macros.svh]
// Assertion macros shared by the interrupt controller RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on an explicit clock and active-low reset.
`define VIC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the usual clk_i / rst_ni pair.
`define VIC_ASSERT(lbl, prop, msg) \
  `VIC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[src/vic_pkg.sv]
// Types and constants of the vectored interrupt controller.
// No dependencies; used by the request interface and the top level.
`default_nettype none

package vic_pkg;

  localparam int unsigned NumChannels = 16;
  localparam int unsigned ChanW       = 4;
  localparam int unsigned NumPins     = 8;

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_REQUEST = 2'd2,
    ACT_ACK     = 2'd3
  } action_e;

  // Register offsets (low six address bits)
  localparam logic [5:0] OFF_PORT     = 6'h01;
  localparam logic [5:0] OFF_EDGE     = 6'h03;
  localparam logic [5:0] OFF_DIR      = 6'h05;
  localparam logic [5:0] OFF_ENA_HI   = 6'h07;
  localparam logic [5:0] OFF_ENA_LO   = 6'h09;
  localparam logic [5:0] OFF_PEND_HI  = 6'h0B;
  localparam logic [5:0] OFF_PEND_LO  = 6'h0D;
  localparam logic [5:0] OFF_ISVC_HI  = 6'h0F;
  localparam logic [5:0] OFF_ISVC_LO  = 6'h11;
  localparam logic [5:0] OFF_MASK_HI  = 6'h13;
  localparam logic [5:0] OFF_MASK_LO  = 6'h15;
  localparam logic [5:0] OFF_VECTOR   = 6'h17;

  localparam logic [7:0] PortLatchReset  = 8'hFF;
  localparam logic [7:0] VectorBaseMask  = 8'hF0;
  localparam int unsigned SwEoiBit       = 3;

  // Channel served by each port pin
  localparam logic [ChanW-1:0] PinChannel [NumPins] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd6, 4'd7, 4'd14, 4'd15
  };

  typedef struct packed {
    logic             valid;
    logic [ChanW-1:0] chan;
  } elig_t;

endpackage

`default_nettype wire

[src/vic_req_if.sv]
// Request channel of the interrupt controller: valid/ready plus item fields.
// Depends on vic_pkg.
`default_nettype none

interface vic_req_if;
  logic            valid;
  logic            ready;
  vic_pkg::action_e action;
  logic [5:0]      reg_offset;
  logic [7:0]      write_data;
  logic [3:0]      src;
  logic [7:0]      pin_levels;

  modport source (output valid, action, reg_offset, write_data, src, pin_levels,
                  input ready);
  modport sink   (input valid, action, reg_offset, write_data, src, pin_levels,
                  output ready);
endinterface

`default_nettype wire

[src/vic_rsp_if.sv]
// Result channel of the interrupt controller: valid/ready plus result fields.
// Depends on nothing beyond the language.
`default_nettype none

interface vic_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_active;
  logic [7:0] ack_vector;
  logic       ack_spurious;

  modport source (output valid, read_data, irq_active, ack_vector, ack_spurious,
                  input ready);
  modport sink   (input valid, read_data, irq_active, ack_vector, ack_spurious,
                  output ready);
endinterface

`default_nettype wire

[src/vectored_interrupt_controller.sv]
// Vectored interrupt controller top level: 16 prioritised channels, 8-bit port.
// Depends on vic_pkg, vic_req_if, vic_rsp_if and assert_macros.svh.
//
// Each request is a register read, a register write, a source request or an
// interrupt acknowledge, and yields exactly one result. A request is first
// captured in an input register; once the result register is free or being
// emptied, the register file is updated and the result (read data, IRQ level
// after the request, vector and spurious flag) is captured in a result
// register. A new request is accepted every cycle while results are taken
// without stall. While a result waits to be taken, the input register still
// takes one more request. Channel 15 has the highest priority; port pins
// 0..7 map to channels 0,1,2,3,6,7,14,15.
`default_nettype none
`include "assert_macros.svh"

module vectored_interrupt_controller (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vic_req_if.sink    req_i,
  vic_rsp_if.source  rsp_o
);

  // Find the highest pending, unmasked channel that outranks in-service ones
  function automatic vic_pkg::elig_t find_eligible(
    input logic [vic_pkg::NumChannels-1:0] pend,
    input logic [vic_pkg::NumChannels-1:0] msk,
    input logic [vic_pkg::NumChannels-1:0] isvc
  );
    logic [vic_pkg::NumChannels-1:0] cand;
    logic [vic_pkg::ChanW-1:0]       p_idx;
    logic [vic_pkg::ChanW-1:0]       s_idx;
    logic                            p_any;
    logic                            s_any;
    vic_pkg::elig_t                  r;
    cand  = pend & msk;
    p_idx = '0;
    s_idx = '0;
    p_any = 1'b0;
    s_any = 1'b0;
    for (int b = 0; b < vic_pkg::NumChannels; b++) begin
      if (cand[b]) begin
        p_idx = vic_pkg::ChanW'(b);
        p_any = 1'b1;
      end
      if (isvc[b]) begin
        s_idx = vic_pkg::ChanW'(b);
        s_any = 1'b1;
      end
    end
    r.valid = p_any && (!s_any || (p_idx > s_idx));
    r.chan  = p_idx;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic             in_valid_q;
  vic_pkg::action_e act_q;
  logic [5:0]       off_q;
  logic [7:0]       wdata_q;
  logic [3:0]       src_q;
  logic [7:0]       pins_q;

  logic rsp_valid_q;
  logic advance;
  logic fire;

  // Advance when the result register is free or being emptied
  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign fire        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      act_q   <= req_i.action;
      off_q   <= req_i.reg_offset;
      wdata_q <= req_i.write_data;
      src_q   <= req_i.src;
      pins_q  <= req_i.pin_levels;
    end
  end

  // ---------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------
  logic [7:0]                      port_latch_q, port_latch_d;
  logic [7:0]                      edge_sel_q, edge_sel_d;
  logic [7:0]                      pin_dir_q, pin_dir_d;
  logic [vic_pkg::NumChannels-1:0] enable_q, enable_d;
  logic [vic_pkg::NumChannels-1:0] pending_q, pending_d;
  logic [vic_pkg::NumChannels-1:0] mask_q, mask_d;
  logic [vic_pkg::NumChannels-1:0] in_svc_q, in_svc_d;
  logic [7:0]                      vector_q, vector_d;

  logic [7:0]     rd_data;
  logic [7:0]     ack_vec;
  logic           ack_spur;
  logic [7:0]     edge_changed;
  vic_pkg::elig_t elig_now;
  vic_pkg::elig_t elig_next;

  assign elig_now     = find_eligible(pending_q, mask_q, in_svc_q);
  assign edge_changed = edge_sel_q ^ wdata_q;

  always_comb begin
    port_latch_d = port_latch_q;
    edge_sel_d   = edge_sel_q;
    pin_dir_d    = pin_dir_q;
    enable_d     = enable_q;
    pending_d    = pending_q;
    mask_d       = mask_q;
    in_svc_d     = in_svc_q;
    vector_d     = vector_q;
    rd_data      = '0;
    ack_vec      = '0;
    ack_spur     = 1'b0;

    unique case (act_q)
      vic_pkg::ACT_READ: begin
        unique case (off_q)
          vic_pkg::OFF_PORT:    rd_data = (port_latch_q & pin_dir_q) | (pins_q & ~pin_dir_q);
          vic_pkg::OFF_EDGE:    rd_data = edge_sel_q;
          vic_pkg::OFF_DIR:     rd_data = pin_dir_q;
          vic_pkg::OFF_ENA_HI:  rd_data = enable_q[15:8];
          vic_pkg::OFF_ENA_LO:  rd_data = enable_q[7:0];
          vic_pkg::OFF_PEND_HI: rd_data = pending_q[15:8];
          vic_pkg::OFF_PEND_LO: rd_data = pending_q[7:0];
          vic_pkg::OFF_ISVC_HI: rd_data = in_svc_q[15:8];
          vic_pkg::OFF_ISVC_LO: rd_data = in_svc_q[7:0];
          vic_pkg::OFF_MASK_HI: rd_data = mask_q[15:8];
          vic_pkg::OFF_MASK_LO: rd_data = mask_q[7:0];
          vic_pkg::OFF_VECTOR:  rd_data = vector_q;
          default:              rd_data = '0;
        endcase
      end
      vic_pkg::ACT_WRITE: begin
        unique case (off_q)
          vic_pkg::OFF_PORT: port_latch_d = wdata_q;
          vic_pkg::OFF_EDGE: begin
            edge_sel_d = wdata_q;
            // Raise input pins whose newly selected edge is already present
            for (int b = 0; b < vic_pkg::NumPins; b++) begin
              if (!pin_dir_q[b] && edge_changed[b] && (pins_q[b] == wdata_q[b])) begin
                pending_d[vic_pkg::PinChannel[b]] = enable_q[vic_pkg::PinChannel[b]];
              end
            end
          end
          vic_pkg::OFF_DIR: pin_dir_d = wdata_q;
          vic_pkg::OFF_ENA_HI: begin
            enable_d  = {wdata_q, enable_q[7:0]};
            pending_d = pending_q & {wdata_q, enable_q[7:0]};
          end
          vic_pkg::OFF_ENA_LO: begin
            enable_d  = {enable_q[15:8], wdata_q};
            pending_d = pending_q & {enable_q[15:8], wdata_q};
          end
          vic_pkg::OFF_PEND_HI: pending_d = pending_q & {wdata_q, 8'hFF};
          vic_pkg::OFF_PEND_LO: pending_d = pending_q & {8'hFF, wdata_q};
          vic_pkg::OFF_ISVC_HI: in_svc_d  = in_svc_q & {wdata_q, 8'hFF};
          vic_pkg::OFF_ISVC_LO: in_svc_d  = in_svc_q & {8'hFF, wdata_q};
          vic_pkg::OFF_MASK_HI: mask_d    = {wdata_q, mask_q[7:0]};
          vic_pkg::OFF_MASK_LO: mask_d    = {mask_q[15:8], wdata_q};
          vic_pkg::OFF_VECTOR:  vector_d  = wdata_q;
          default: ;
        endcase
      end
      vic_pkg::ACT_REQUEST: begin
        // Enabled channel goes pending, disabled one drops its pending bit
        pending_d[src_q] = enable_q[src_q];
      end
      vic_pkg::ACT_ACK: begin
        if (elig_now.valid) begin
          pending_d[elig_now.chan] = 1'b0;
          in_svc_d[elig_now.chan]  = vector_q[vic_pkg::SwEoiBit];
          ack_vec = (vector_q & vic_pkg::VectorBaseMask) | {4'b0, elig_now.chan};
        end else begin
          ack_spur = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // IRQ level as seen after this request
  assign elig_next = find_eligible(pending_d, mask_d, in_svc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_latch_q <= vic_pkg::PortLatchReset;
      edge_sel_q   <= '0;
      pin_dir_q    <= '0;
      enable_q     <= '0;
      pending_q    <= '0;
      mask_q       <= '0;
      in_svc_q     <= '0;
      vector_q     <= '0;
    end else if (fire) begin
      port_latch_q <= port_latch_d;
      edge_sel_q   <= edge_sel_d;
      pin_dir_q    <= pin_dir_d;
      enable_q     <= enable_d;
      pending_q    <= pending_d;
      mask_q       <= mask_d;
      in_svc_q     <= in_svc_d;
      vector_q     <= vector_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [7:0] rd_data_q;
  logic       irq_q;
  logic [7:0] ack_vec_q;
  logic       ack_spur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_data_q  <= rd_data;
      irq_q      <= elig_next.valid;
      ack_vec_q  <= ack_vec;
      ack_spur_q <= ack_spur;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.read_data    = rd_data_q;
  assign rsp_o.irq_active   = irq_q;
  assign rsp_o.ack_vector   = ack_vec_q;
  assign rsp_o.ack_spurious = ack_spur_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `VIC_ASSERT(a_pend_needs_enable, ((pending_q & ~enable_q) == '0), "pending bit on disabled channel")
  `VIC_ASSERT(a_spur_no_vector, (rsp_valid_q && ack_spur_q) |-> (ack_vec_q == '0), "spurious ack with vector")
  `VIC_ASSERT(a_spur_no_irq, (rsp_valid_q && ack_spur_q) |-> !irq_q, "IRQ raised after spurious ack")
  `VIC_ASSERT(a_hold_on_stall, (in_valid_q && !advance) |=> (in_valid_q && $stable(pending_q)), "state moved while stalled")

endmodule

`default_nettype wire
